>>> rtl/pow2_segregated_free_list_allocator_top_defines.svh
// Assertion macros for the size-class allocator
`ifndef POW2_SEGREGATED_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define POW2_SEGREGATED_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
// assert that a condition implies a consequence on the next edge
`define PSA_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
// assert that a condition implies a consequence on the same edge
`define PSA_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
`endif

>>> rtl/psa_pkg.sv
// Shared types and constants of the size-class allocator
package psa_pkg;
  localparam int NumClasses = 32;
  localparam int StackDepth = 256;
  localparam int ClsW = $clog2(NumClasses);
  localparam int PtrW = $clog2(StackDepth);
  localparam int CntW = PtrW + 1;
  localparam int StoreDepth = NumClasses * StackDepth;
  localparam int StoreAw = $clog2(StoreDepth);
  localparam logic [ClsW-1:0] MaxCls = ClsW'(NumClasses - 1);
  localparam logic [4:0] MinClass = 5'd4;

  localparam logic [1:0] CmdIdxFresh = 2'd0;
  localparam logic [1:0] CmdIdxBase = 2'd1;
  localparam logic [1:0] CmdIdxLimit = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StOut = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_WAIT, S_SPLIT, S_DONE
  } state_t;

  typedef struct packed {
    logic we;
    logic [StoreAw-1:0] waddr;
    logic [31:0] wdata;
    logic re;
    logic [StoreAw-1:0] raddr;
  } store_req_t;

  function automatic logic [StoreAw-1:0] store_addr(logic [ClsW-1:0] c, logic [PtrW-1:0] p);
    return {c, p};
  endfunction
endpackage

>>> rtl/psa_ram.sv
// Generic single-write, single-read RAM with registered read
module psa_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> rtl/psa_ctrl.sv
// Allocation sequencer: free pushes, class search, pop, split pushes, bump carving
module psa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [31:0]         block_size,
  input  logic [31:0]         free_addr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         block_addr,
  output logic [31:0]         granted_size,
  output logic [1:0]          status,
  output psa_pkg::store_req_t store_req,
  input  logic [31:0]         store_rdata,
  output psa_pkg::state_t     state_o
);
  import psa_pkg::*;

  state_t state, state_next;
  logic [4:0] fresh_class;
  logic [31:0] region_base, region_limit;
  logic [32:0] bump_pointer;
  logic [CntW-1:0] fill [NumClasses];
  logic [ClsW-1:0] req, cur;
  logic [31:0] p;
  logic [31:0] res_addr, res_size;
  logic [1:0] res_st;

  logic [5:0] size_cls, req_cls;
  logic [32:0] sz;
  logic [ClsW-1:0] fc;
  logic [ClsW-1:0] fresh_cur;
  logic [32:0] end_addr;
  logic [ClsW-1:0] lower;
  logic lower_full;

  always_comb begin
    sz = {1'b0, block_size};
    size_cls = 6'd0;
    for (int i = 1; i < 32; i++) begin
      if (sz[i]) size_cls = 6'(i);
    end
    req_cls = {1'b0, MinClass};
    for (int i = 5; i < 33; i++) begin
      if (sz > (33'd1 << (i - 1))) req_cls = 6'(i);
    end
    fc = ({1'b0, fresh_class} >= 6'(NumClasses)) ? MaxCls : ClsW'(fresh_class);
    fresh_cur = (req > fc) ? req : fc;
    end_addr = bump_pointer + ((33'd1 << fresh_cur) - 33'd1);
    lower = cur - ClsW'(1);
    lower_full = (fill[lower] >= CntW'(StackDepth));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fresh_class <= 5'd16;
      region_base <= '0;
      region_limit <= '1;
      bump_pointer <= '0;
      for (int i = 0; i < NumClasses; i++) fill[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CmdIdxFresh: fresh_class <= cfg_data[4:0];
          CmdIdxBase: begin
            region_base <= cfg_data;
            bump_pointer <= {1'b0, cfg_data};
          end
          CmdIdxLimit: region_limit <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          res_addr <= '0;
          res_size <= '0;
          if (cmd == CmdFree) begin
            if (block_size != 32'd0 && size_cls < 6'(NumClasses)
                && fill[ClsW'(size_cls)] >= CntW'(StackDepth)) begin
              res_st <= StFull;
            end else begin
              res_st <= StOk;
              if (block_size != 32'd0 && size_cls < 6'(NumClasses)) begin
                fill[ClsW'(size_cls)] <= fill[ClsW'(size_cls)] + CntW'(1);
              end
            end
          end else if (block_size > 32'h8000_0000 || req_cls >= 6'(NumClasses)) begin
            res_st <= StOut;
          end else begin
            res_st <= StOk;
            req <= ClsW'(req_cls);
            cur <= ClsW'(req_cls);
          end
        end
        S_SCAN: begin
          if (fill[cur] != '0) begin
            fill[cur] <= fill[cur] - CntW'(1);
          end else if (cur == MaxCls) begin
            if (end_addr > {1'b0, region_limit}) begin
              res_st <= StOut;
            end else begin
              p <= bump_pointer[31:0];
              bump_pointer <= bump_pointer + (33'd1 << fresh_cur);
              cur <= fresh_cur;
            end
          end else begin
            cur <= cur + ClsW'(1);
          end
        end
        S_WAIT: p <= store_rdata;
        S_SPLIT: begin
          if (cur != req) begin
            cur <= lower;
            if (lower_full) res_st <= StFull;
            else fill[lower] <= fill[lower] + CntW'(1);
          end else begin
            res_addr <= p;
            res_size <= 32'd1 << req;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    store_req = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cmd == CmdFree) begin
            state_next = S_DONE;
            if (block_size != 32'd0 && size_cls < 6'(NumClasses)
                && fill[ClsW'(size_cls)] < CntW'(StackDepth)) begin
              store_req.we = 1'b1;
              store_req.waddr = store_addr(ClsW'(size_cls), fill[ClsW'(size_cls)][PtrW-1:0]);
              store_req.wdata = free_addr;
            end
          end else if (block_size > 32'h8000_0000 || req_cls >= 6'(NumClasses)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (fill[cur] != '0) begin
          state_next = S_READ;
          store_req.re = 1'b1;
          store_req.raddr = store_addr(cur, PtrW'(fill[cur] - CntW'(1)));
        end else if (cur == MaxCls) begin
          state_next = (end_addr > {1'b0, region_limit}) ? S_DONE : S_SPLIT;
        end
      end
      S_READ: state_next = S_WAIT;
      S_WAIT: state_next = S_SPLIT;
      S_SPLIT: begin
        if (cur != req) begin
          if (!lower_full) begin
            store_req.we = 1'b1;
            store_req.waddr = store_addr(lower, fill[lower][PtrW-1:0]);
            store_req.wdata = p + (32'd1 << lower);
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign block_addr = res_addr;
  assign granted_size = res_size;
  assign status = res_st;
  assign state_o = state;
endmodule

>>> rtl/pow2_segregated_free_list_allocator_top.sv
// Top level of the power-of-two size-class allocator
// Usage:
//   Input channel in_valid/in_ready carries cmd, block_size and free_addr;
//   one result (block_addr, granted_size, status) leaves on out_valid/out_ready.
//   Configuration: cfg_we with cfg_index 0 fresh_class, 1 region_base (also
//   resets the bump pointer), 2 region_limit; write only while idle.
// Sequence:
//   A free, or an allocation refused for its size, presents its result the
//   cycle after the transfer. An allocation walks S_SCAN up one class at a
//   time (up to 27 classes); a non-empty stack is popped via S_READ and S_WAIT.
//   If all stacks up to class 31 are empty, a block of the larger of the
//   request and fresh_class is carved from the bump pointer. S_SPLIT then
//   pushes one half per class down to the request (up to 27), then S_DONE.
// Throughput: one item at a time; the next is taken from the cycle after the
//   result transfers.
// Reset: all stacks empty, fresh_class 16, region 0..0xFFFFFFFF, no clearing
//   pass (the store is only read after being written).
// Stall: the result holds on the outputs while out_ready is low, and no new
//   item is taken until it transfers.
`include "pow2_segregated_free_list_allocator_top_defines.svh"
module pow2_segregated_free_list_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] block_size,
  input  logic [31:0] free_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] block_addr,
  output logic [31:0] granted_size,
  output logic [1:0]  status
);
  import psa_pkg::*;

  store_req_t store_req;
  logic [31:0] store_rdata;
  state_t state;

  psa_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .cmd, .block_size, .free_addr,
    .out_valid, .out_ready, .block_addr, .granted_size, .status,
    .store_req, .store_rdata, .state_o(state)
  );

  psa_ram #(.Width(32), .Depth(StoreDepth)) u_store (
    .clk,
    .we(store_req.we),
    .waddr(store_req.waddr),
    .wdata(store_req.wdata),
    .re(store_req.re),
    .raddr(store_req.raddr),
    .rdata(store_rdata)
  );

  `PSA_ASSERT_NOW(a_excl, in_ready, !out_valid, "input and output open together")
  `PSA_ASSERT_NOW(a_okgrant, out_valid && status == StOut, granted_size == 32'd0,
    "size granted on failure")
  `PSA_ASSERT_NOW(a_rw, store_req.we, !store_req.re, "store read and write together")
  `PSA_ASSERT_NEXT(a_read, state == S_READ, state == S_WAIT, "store read not awaited")
endmodule

>>> bench/testbench.sv
// Self-checking bench for the power-of-two size-class allocator
`timescale 1ns / 100ps
module testbench;
  import psa_pkg::*;

  class alloc_scoreboard;
    logic [31:0] stack_mem [NumClasses][StackDepth];
    int          fill [NumClasses];
    logic [32:0] bump;
    logic [4:0]  fresh;
    logic [31:0] base_addr;
    logic [31:0] limit_addr;
    logic [31:0] want_addr [$];
    logic [31:0] want_size [$];
    logic [1:0]  want_st [$];
    int          errors;

    function new();
      for (int c = 0; c < NumClasses; c++) fill[c] = 0;
      fresh = 5'd16;
      base_addr = '0;
      limit_addr = '1;
      bump = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
      if (idx == CmdIdxFresh) fresh = v[4:0];
      else if (idx == CmdIdxBase) begin
        base_addr = v;
        bump = {1'b0, v};
      end else if (idx == CmdIdxLimit) limit_addr = v;
    endfunction

    function bit push_blk(int c, logic [31:0] a);
      if (c >= NumClasses || fill[c] >= StackDepth) return 0;
      stack_mem[c][fill[c]] = a;
      fill[c]++;
      return 1;
    endfunction

    function void note_item(logic op, logic [31:0] sz, logic [31:0] fa);
      logic [1:0]  st;
      logic [31:0] ad;
      logic [31:0] gr;
      logic [31:0] p;
      logic [33:0] bsz;
      int          req;
      int          cur;
      int          fc;
      st = StOk;
      ad = '0;
      gr = '0;
      p = '0;
      if (op == CmdFree) begin
        if (sz != 0) begin
          cur = 0;
          while (cur < 31 && (sz >> (cur + 1)) != 0) cur++;
          if (cur < NumClasses && !push_blk(cur, fa)) st = StFull;
        end
      end else if (sz > 32'h8000_0000) begin
        st = StOut;
      end else begin
        req = MinClass;
        while ((64'd1 << req) < {32'd0, sz}) req++;
        if (req >= NumClasses) st = StOut;
        else begin
          cur = req;
          while (cur < NumClasses && fill[cur] == 0) cur++;
          if (cur >= NumClasses) begin
            fc = fresh;
            if (fc >= NumClasses) fc = NumClasses - 1;
            cur = req > fc ? req : fc;
            bsz = 34'd1 << cur;
            if ({1'b0, bump} + bsz - 1 > {2'b0, limit_addr}) st = StOut;
            else begin
              p = bump[31:0];
              bump = bump + bsz[32:0];
            end
          end else begin
            fill[cur]--;
            p = stack_mem[cur][fill[cur]];
          end
          if (st == StOk) begin
            while (cur != req) begin
              cur--;
              if (!push_blk(cur, p + (32'd1 << cur))) st = StFull;
            end
            ad = p;
            gr = 32'd1 << req;
          end
        end
      end
      want_addr.push_back(ad);
      want_size.push_back(gr);
      want_st.push_back(st);
    endfunction

    function void check_result(logic [31:0] ad, logic [31:0] gr, logic [1:0] st);
      logic [31:0] ea;
      logic [31:0] eg;
      logic [1:0]  es;
      if (want_st.size() == 0) begin
        $display("%0t: unexpected result addr %h size %h status %0d", $time, ad, gr, st);
        errors++;
        return;
      end
      ea = want_addr.pop_front();
      eg = want_size.pop_front();
      es = want_st.pop_front();
      if (ad !== ea) begin
        $display("%0t: block_addr expected %h actual %h", $time, ea, ad);
        errors++;
      end
      if (gr !== eg) begin
        $display("%0t: granted_size expected %h actual %h", $time, eg, gr);
        errors++;
      end
      if (st !== es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CmdAlloc;
  logic [31:0] block_size = '0;
  logic [31:0] free_addr = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] block_addr;
  logic [31:0] granted_size;
  logic [1:0]  status;

  alloc_scoreboard sb = new();
  int  cycle_count = 0;
  bit  calm = 0;
  logic [31:0] live_addr [$];
  logic [31:0] live_size [$];

  always #5 clk = ~clk;

  pow2_segregated_free_list_allocator_top i_dut (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result(block_addr, granted_size, status);
        if (status != StOut && granted_size != 0) begin
          live_addr.push_back(block_addr);
          live_size.push_back(granted_size);
        end
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
    end
  end

  task automatic send_item(logic op, logic [31:0] sz, logic [31:0] fa);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= op;
    block_size <= sz;
    free_addr <= fa;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, sz, fa);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.want_st.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_size();
    int k;
    k = $urandom_range(99);
    if (k < 70) return $urandom_range(300);
    if (k < 90) return $urandom_range(1 << $urandom_range(16), 1);
    return $urandom;
  endfunction

  task automatic random_phase(int n);
    int          k;
    logic [31:0] a;
    logic [31:0] s;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 50) send_item(CmdAlloc, rand_size(), $urandom);
      else if (k < 85 && live_addr.size() != 0) begin
        k = $urandom_range(live_addr.size() - 1);
        a = live_addr[k];
        s = live_size[k];
        live_addr.delete(k);
        live_size.delete(k);
        send_item(CmdFree, s, a);
      end else send_item(CmdFree, rand_size(), $urandom);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_item(CmdAlloc, 32'd0, 32'hFFFF_FFFF);
    send_item(CmdAlloc, 32'd1, 32'd0);
    send_item(CmdAlloc, 32'd17, 32'd0);
    send_item(CmdAlloc, 32'h8000_0000, 32'd0);
    send_item(CmdAlloc, 32'h8000_0001, 32'd0);
    send_item(CmdAlloc, 32'hFFFF_FFFF, 32'd0);
    send_item(CmdFree, 32'd0, 32'h1234_5678);
    send_item(CmdFree, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_item(CmdFree, 32'd1, 32'hAAAA_5555);
    send_item(CmdFree, 32'd48, 32'h5555_AAAA);
    send_item(CmdAlloc, 32'd32, 32'd0);
    send_item(CmdAlloc, 32'd20, 32'd0);
    for (int i = 0; i < 258; i++) send_item(CmdFree, 32'd16, i * 16);
    drain();
    set_reg(CmdIdxFresh, 32'd31);
    set_reg(CmdIdxBase, 32'hFFFF_FF00);
    set_reg(CmdIdxLimit, 32'hFFFF_FFFF);
    send_item(CmdAlloc, 32'd64, 32'd0);
    drain();
    set_reg(CmdIdxFresh, 32'd4);
    set_reg(CmdIdxBase, 32'hFFFF_FF00);
    send_item(CmdAlloc, 32'd256, 32'd0);
    send_item(CmdAlloc, 32'd16, 32'd0);
    drain();
    set_reg(CmdIdxFresh, 32'd0);
    set_reg(CmdIdxBase, 32'h0001_0000);
    set_reg(CmdIdxLimit, 32'h0000_0000);
    send_item(CmdAlloc, 32'd16, 32'd0);
    drain();
    set_reg(CmdIdxFresh, 32'd12);
    set_reg(CmdIdxBase, 32'h1000_0000);
    set_reg(CmdIdxLimit, 32'h1004_0000);
    random_phase(230);
    drain();
    calm = 1;
    random_phase(130);
    calm = 0;
    drain();
    set_reg(CmdIdxFresh, 32'd8);
    set_reg(CmdIdxBase, $urandom);
    set_reg(CmdIdxLimit, 32'hFFFF_FFFF);
    random_phase(220);
    drain();
    if (sb.errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
